// ===== sv/csd_pkg.sv =====
// Shared types and constants for the camera sensor dither unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package csd_pkg;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_CAPTURE = 2'd2,
      OP_PIXEL   = 2'd3
   } op_type;

   localparam logic [15:0] BUS_BASE      = 16'hA000;
   localparam logic [6:0]  OFFSET_MASK   = 7'h7F;
   localparam logic [6:0]  OFF_TRIGGER   = 7'h00;
   localparam logic [6:0]  OFF_MODE      = 7'h01;
   localparam logic [6:0]  OFF_EXPO_HI   = 7'h02;
   localparam logic [6:0]  OFF_EXPO_LO   = 7'h03;
   localparam logic [6:0]  OFF_MATRIX    = 7'h06;
   localparam logic [6:0]  OFF_MATRIX_END = 7'h36;
   localparam logic [7:0]  TRIGGER_MASK  = 8'h06;

   localparam logic [20:0] BASE_CYCLES   = 21'd32446;
   localparam logic [20:0] NO_BIT7_EXTRA = 21'd512;
   localparam int unsigned CYCLE_SHIFT   = 4;
   localparam int unsigned EXPO_SHIFT    = 11;
   localparam logic [7:0]  PIXEL_MAX     = 8'd255;

   // index / 3 as (index * 43) >> 7, exact for indexes below 48
   localparam logic [5:0]  DIV3_MUL      = 6'd43;
   localparam int unsigned DIV3_SHIFT    = 7;

   localparam int unsigned NUM_SLOTS     = 3;
   localparam int unsigned NUM_ROWS      = 16;
   localparam int unsigned ROW_BITS      = 4;
   localparam int unsigned DATA_W        = 88;
   localparam int unsigned RSP_W         = 16;

   typedef struct packed {
      logic        accept;
      op_type      op;
      logic [15:0] address;
      logic [7:0]  wdata;
      logic [47:0] cycle;
   } req_type;

   typedef struct packed {
      logic                en;
      logic [ROW_BITS-1:0] row;
      logic [1:0]          slot;
      logic [7:0]          data;
   } thr_wr_type;

endpackage

`default_nettype wire

// ===== sv/camera_sensor_regs_dither_unit.sv =====
// Camera sensor register file with capture timing and ordered pixel dither.
// Takes one request per cycle unless the response side stalls (bus write, bus read,
// capture start or pixel) and returns exactly one response per request, in order, from
// the stage 1 and stage 2 registers. Registers are updated when a request is accepted,
// so later requests always see earlier writes. The 48-byte threshold matrix sits in
// three 16-entry synchronous banks addressed by {row_phase, col_phase}; a single read
// fetches all three thresholds of a pixel. Valid bits cleared by reset stand in for
// the zeroed matrix, so no clearing pass follows reset. Depends on csd_pkg, csd_regs
// and csd_thr_mem.
`default_nettype none

module camera_sensor_regs_dither_unit
   import csd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [15:0] address, [23:16] write_data, [71:24] cycle, [79:72] pixel_value,
   // [81:80] row_phase, [83:82] col_phase, [87:84] zero
   input  wire logic [DATA_W-1:0] req_tdata,
   // [1:0] op
   input  wire logic [1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [7:0] read_data, [9:8] pixel_code, [15:10] zero
   output logic [RSP_W-1:0]       rsp_tdata
);

   req_type    req;
   thr_wr_type thr_wr;
   logic       accept;
   logic [15:0] exposure;
   logic [7:0]  status;
   logic [NUM_SLOTS-1:0][7:0] thr;
   logic [7:0]  pixel;
   logic [23:0] product;
   logic [12:0] scaled;
   logic [7:0]  clamped;

   logic        s1_valid_ff, s1_valid_in;
   op_type      s1_op_ff;
   logic [7:0]  s1_rd_ff;
   logic [7:0]  s1_v_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [7:0]  s2_rd_ff, s2_rd_in;
   logic [1:0]  s2_code_ff, s2_code_in;
   op_type      s2_op_ff;
   logic        s2_ready;
   logic        s1_adv;

   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign accept     = req_tvalid && req_tready;

   assign req.accept  = accept;
   assign req.op      = op_type'(req_tuser);
   assign req.address = req_tdata[15:0];
   assign req.wdata   = req_tdata[23:16];
   assign req.cycle   = req_tdata[71:24];
   assign pixel       = req_tdata[79:72];

   csd_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .exposure (exposure),
      .status   (status),
      .thr_wr   (thr_wr)
   );

   csd_thr_mem u_thr_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (thr_wr),
      .rd_en   (accept),
      .rd_row  ({req_tdata[81:80], req_tdata[83:82]}),
      .rd_data (thr)
   );

   assign product = {8'd0, exposure} * {16'd0, pixel};
   assign scaled  = product[23:EXPO_SHIFT];
   assign clamped = (scaled > {5'd0, PIXEL_MAX}) ? PIXEL_MAX : scaled[7:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
      s2_rd_in   = (s1_op_ff == OP_READ) ? s1_rd_ff : 8'd0;
      s2_code_in = 2'd0;
      if (s1_op_ff == OP_PIXEL) begin
         priority if (s1_v_ff < thr[0]) begin
            s2_code_in = 2'd3;
         end else if (s1_v_ff < thr[1]) begin
            s2_code_in = 2'd2;
         end else if (s1_v_ff < thr[2]) begin
            s2_code_in = 2'd1;
         end else begin
            s2_code_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= req.op;
         s1_rd_ff <= status;
         s1_v_ff  <= clamped;
      end
      if (s1_adv) begin
         s2_op_ff   <= s1_op_ff;
         s2_rd_ff   <= s2_rd_in;
         s2_code_ff <= s2_code_in;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {6'd0, s2_code_ff, s2_rd_ff};

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request did not enter stage 1");

   a_stall_keeps_s1: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |-> !req_tready)
      else $error("request taken while stage 1 is stalled");

   a_code_only_pixel: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_op_ff != OP_PIXEL) |-> (s2_code_ff == 2'd0))
      else $error("pixel code on a non-pixel response");

   a_read_only_status: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> ((s2_rd_ff[7:3] == 5'd0)
                       && (s2_op_ff == OP_READ || s2_rd_ff == 8'd0)))
      else $error("bad read data on response");

endmodule

`default_nettype wire

// ===== sv/csd_thr_mem.sv =====
// Dither threshold matrix: three 16-entry synchronous banks, one per
// threshold slot, with per-entry valid bits. Depends on csd_pkg.
`default_nettype none

module csd_thr_mem
   import csd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire thr_wr_type          wr,
   input  wire logic                rd_en,
   input  wire logic [ROW_BITS-1:0] rd_row,
   output logic [NUM_SLOTS-1:0][7:0] rd_data
);

   for (genvar b = 0; b < NUM_SLOTS; b++) begin : g_bank
      logic [7:0]          mem [NUM_ROWS];
      logic [NUM_ROWS-1:0] vld_ff;
      logic [7:0]          rdata_ff;
      logic                rvld_ff;
      logic                wr_hit;

      assign wr_hit = wr.en && (wr.slot == 2'(b));

      always_ff @(posedge clock) begin
         if (wr_hit) begin
            mem[wr.row] <= wr.data;
         end
         if (rd_en) begin
            rdata_ff <= mem[rd_row];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff  <= '0;
            rvld_ff <= 1'b0;
         end else begin
            if (wr_hit) begin
               vld_ff[wr.row] <= 1'b1;
            end
            if (rd_en) begin
               rvld_ff <= vld_ff[rd_row];
            end
         end
      end

      assign rd_data[b] = rvld_ff ? rdata_ff : 8'd0;
   end

endmodule

`default_nettype wire

// ===== sv/csd_regs.sv =====
// Sensor register file: trigger, mode, exposure and capture end cycle.
// Decodes bus writes, forms the status byte. Depends on csd_pkg.
`default_nettype none

module csd_regs
   import csd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   output logic [15:0]  exposure,
   output logic [7:0]   status,
   output thr_wr_type   thr_wr
);

   logic [1:0]  trig_ff, trig_in;
   logic [7:0]  mode_ff, mode_in;
   logic [15:0] expo_ff, expo_in;
   logic [48:0] end_ff, end_in;
   logic [6:0]  off;
   logic [5:0]  idx;
   logic [11:0] idx_prod;
   logic [3:0]  idx_row;
   logic [5:0]  row_x3;
   logic [20:0] cap_cycles;
   logic        busy;
   logic        in_matrix;

   assign off       = (req.address[6:0] - BUS_BASE[6:0]) & OFFSET_MASK;
   assign in_matrix = (off >= OFF_MATRIX) && (off < OFF_MATRIX_END);
   assign idx       = 6'(off - OFF_MATRIX);
   assign idx_prod  = {6'd0, idx} * {6'd0, DIV3_MUL};
   assign idx_row   = idx_prod[DIV3_SHIFT +: ROW_BITS];
   assign row_x3    = {2'd0, idx_row} + {1'b0, idx_row, 1'b0};

   assign thr_wr.en   = req.accept && (req.op == OP_WRITE) && in_matrix;
   assign thr_wr.row  = idx_row;
   assign thr_wr.slot = 2'(idx - row_x3);
   assign thr_wr.data = req.wdata;

   assign cap_cycles = BASE_CYCLES + (mode_ff[7] ? 21'd0 : NO_BIT7_EXTRA)
                       + {1'b0, expo_ff, 4'd0};
   assign busy       = {1'b0, req.cycle} < end_ff;
   assign status     = (req.address == BUS_BASE) ? {5'd0, trig_ff, busy} : 8'd0;
   assign exposure   = expo_ff;

   always_comb begin
      trig_in = trig_ff;
      mode_in = mode_ff;
      expo_in = expo_ff;
      end_in  = end_ff;
      if (req.accept) begin
         unique case (req.op)
            OP_WRITE: begin
               priority if (off == OFF_TRIGGER) begin
                  trig_in = 2'((req.wdata & TRIGGER_MASK) >> 1);
               end else if (off == OFF_MODE) begin
                  mode_in = req.wdata;
               end else if (off == OFF_EXPO_HI) begin
                  expo_in = {req.wdata, expo_ff[7:0]};
               end else if (off == OFF_EXPO_LO) begin
                  expo_in = {expo_ff[15:8], req.wdata};
               end else begin
               end
            end
            OP_CAPTURE: begin
               end_in = {1'b0, req.cycle} + {28'd0, cap_cycles};
            end
            OP_READ, OP_PIXEL: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= '0;
         mode_ff <= '0;
         expo_ff <= '0;
         end_ff  <= '0;
      end else begin
         trig_ff <= trig_in;
         mode_ff <= mode_in;
         expo_ff <= expo_in;
         end_ff  <= end_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_camera_sensor_regs_dither_unit.sv =====
// Self-checking testbench for camera_sensor_regs_dither_unit: register writes, status reads,
// capture timing and ordered pixel dither, checked against a scoreboard's own register shadow.
// Depends on csd_pkg and the camera_sensor_regs_dither_unit RTL.
`default_nettype none

module tb_camera_sensor_regs_dither_unit;
   import csd_pkg::*;

   localparam int unsigned NUM_THRESHOLDS = 48;
   localparam int unsigned ROW_PITCH      = 12;
   localparam int unsigned COL_PITCH      = 3;
   localparam int unsigned EXPO_DIV       = 2048;
   localparam int unsigned RANDOM_ITEMS   = 850;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned MAX_PRINTS     = 100;

   typedef struct packed {
      logic [7:0] status;
      logic [1:0] shade;
   } sensor_rsp;

   class sensor_scoreboard;
      logic [2:0]  trigger;
      logic [7:0]  mode;
      logic [15:0] exposure;
      logic [7:0]  thresholds [NUM_THRESHOLDS];
      logic [47:0] capture_start;
      logic [20:0] capture_len;
      sensor_rsp   expected_rsp[$];
      int unsigned mismatches;

      function new();
         trigger       = '0;
         mode          = '0;
         exposure      = '0;
         capture_start = '0;
         capture_len   = '0;
         mismatches    = 0;
         foreach (thresholds[i]) thresholds[i] = '0;
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      function void note_request(op_type op, logic [15:0] addr, logic [7:0] wdata,
                                 logic [47:0] cyc, logic [7:0] pix, logic [1:0] row,
                                 logic [1:0] col);
         sensor_rsp   rsp;
         logic [15:0] delta;
         logic [6:0]  off;
         logic [48:0] done_at;
         int unsigned scaled;
         int unsigned base;
         rsp   = '0;
         delta = addr - BUS_BASE;
         off   = delta[6:0] & OFFSET_MASK;
         case (op)
            OP_WRITE: begin
               if (off == OFF_TRIGGER)
                  trigger = wdata[2:0] & TRIGGER_MASK[2:0];
               else if (off == OFF_MODE)
                  mode = wdata;
               else if (off == OFF_EXPO_HI)
                  exposure[15:8] = wdata;
               else if (off == OFF_EXPO_LO)
                  exposure[7:0] = wdata;
               else if (off >= OFF_MATRIX && off < OFF_MATRIX_END)
                  thresholds[off - OFF_MATRIX] = wdata;
            end
            OP_READ: begin
               if (addr == BUS_BASE) begin
                  done_at    = {1'b0, capture_start} + {28'd0, capture_len};
                  rsp.status = {5'd0, trigger};
                  if ({1'b0, cyc} < done_at)
                     rsp.status[0] = 1'b1;
               end
            end
            OP_CAPTURE: begin
               capture_start = cyc;
               capture_len   = BASE_CYCLES + (mode[7] ? 21'd0 : NO_BIT7_EXTRA)
                               + {exposure, 4'd0};
            end
            default: begin
               scaled = (int'(exposure) * int'(pix)) / EXPO_DIV;
               if (scaled > 32'(PIXEL_MAX))
                  scaled = 32'(PIXEL_MAX);
               base = row * ROW_PITCH + col * COL_PITCH;
               if (scaled < thresholds[base])
                  rsp.shade = 2'd3;
               else if (scaled < thresholds[base + 1])
                  rsp.shade = 2'd2;
               else if (scaled < thresholds[base + 2])
                  rsp.shade = 2'd1;
               else
                  rsp.shade = 2'd0;
            end
         endcase
         expected_rsp.push_back(rsp);
      endfunction

      task report_mismatch(string field, logic [7:0] got, logic [7:0] want);
         if (mismatches < MAX_PRINTS)
            $display("mismatch on %s: got %h, want %h", field, got, want);
         mismatches++;
      endtask

      task check_response(logic [7:0] status, logic [1:0] shade);
         sensor_rsp want;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with none pending", status, 8'h00);
         end else begin
            want = expected_rsp.pop_front();
            if (status !== want.status)
               report_mismatch("read_data", status, want.status);
            if (shade !== want.shade)
               report_mismatch("pixel_code", {6'd0, shade}, {6'd0, want.shade});
         end
      endtask
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;

   sensor_scoreboard    sb = new();
   int unsigned         burst_left = 0;
   int unsigned         stall_mode = 0;
   int unsigned         stall_count = 0;
   logic [47:0]         last_capture = '0;

   camera_sensor_regs_dither_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata[15:0], req_tdata[23:16],
                            req_tdata[71:24], req_tdata[79:72], req_tdata[81:80],
                            req_tdata[83:82]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[7:0], rsp_tdata[9:8]);
      end
   end

   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_count = $urandom_range(10, 80);
      end
      stall_count--;
      case (stall_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(0, 1));
         2: rsp_tready = ($urandom_range(0, 3) == 0);
         default: rsp_tready = (stall_count % 7) < 3;
      endcase
   end

   function automatic logic [47:0] random_cycle();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[47:0];
   endfunction

   task automatic send_request(op_type op, logic [15:0] addr, logic [7:0] wdata,
                               logic [47:0] cyc, logic [7:0] pix, logic [1:0] row,
                               logic [1:0] col);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tuser  = op;
      req_tdata  = {4'd0, col, row, pix, cyc, wdata, addr};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_CAPTURE)
         last_capture = cyc;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic reg_write(logic [15:0] addr, logic [7:0] wdata);
      send_request(OP_WRITE, addr, wdata, '0, '0, '0, '0);
   endtask

   task automatic random_request();
      int unsigned pick;
      int unsigned sel;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [47:0] cyc;
      pick  = $urandom_range(0, 99);
      addr  = 16'($urandom());
      wdata = 8'($urandom());
      cyc   = random_cycle();
      if (pick < 30) begin
         sel = $urandom_range(0, 9);
         if ($urandom_range(0, 6) != 0) begin
            case (sel)
               0: addr = BUS_BASE | OFF_TRIGGER;
               1: addr = BUS_BASE | OFF_MODE;
               2: begin
                  addr = BUS_BASE | OFF_EXPO_HI;
                  if ($urandom_range(0, 4) != 0)
                     wdata = 8'($urandom_range(0, 24));
               end
               3: addr = BUS_BASE | OFF_EXPO_LO;
               9: addr = BUS_BASE | 16'($urandom_range(OFF_MATRIX_END, OFFSET_MASK));
               default: addr = BUS_BASE | 16'($urandom_range(OFF_MATRIX, OFF_MATRIX_END - 1));
            endcase
            if ($urandom_range(0, 4) == 0)
               addr[15:7] = 9'($urandom());
         end
         send_request(OP_WRITE, addr, wdata, cyc, 8'($urandom()), 2'($urandom()),
                      2'($urandom()));
      end else if (pick < 45) begin
         if ($urandom_range(0, 9) < 7)
            addr = BUS_BASE;
         if ($urandom_range(0, 3) != 0)
            cyc = last_capture + 48'($urandom_range(0, 1_200_000));
         send_request(OP_READ, addr, wdata, cyc, 8'($urandom()), 2'($urandom()),
                      2'($urandom()));
      end else if (pick < 53) begin
         if ($urandom_range(0, 2) == 0)
            cyc = 48'($urandom_range(0, 5_000_000));
         send_request(OP_CAPTURE, addr, wdata, cyc, 8'($urandom()), 2'($urandom()),
                      2'($urandom()));
      end else begin
         send_request(OP_PIXEL, addr, wdata, cyc, 8'($urandom()), 2'($urandom()),
                      2'($urandom()));
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_request(OP_READ, BUS_BASE, '0, '0, '0, '0, '0);
      send_request(OP_READ, BUS_BASE, '0, '1, '0, '0, '0);
      send_request(OP_PIXEL, '0, '0, '0, 8'hFF, 2'd3, 2'd3);
      reg_write(BUS_BASE | OFF_TRIGGER, 8'hFF);
      reg_write(BUS_BASE | OFF_MODE, 8'h80);
      reg_write(BUS_BASE | OFF_EXPO_HI, 8'hFF);
      reg_write(BUS_BASE | OFF_EXPO_LO, 8'hFF);
      reg_write(BUS_BASE | 16'h0004, 8'h55);
      reg_write(BUS_BASE | 16'h0005, 8'hAA);
      reg_write(BUS_BASE | OFF_MATRIX_END, 8'h11);
      reg_write(BUS_BASE | OFFSET_MASK, 8'h22);
      reg_write(16'h2006, 8'h80);
      reg_write(BUS_BASE | 16'h0007, 8'h80);
      reg_write(BUS_BASE | 16'h0008, 8'hC0);
      reg_write(BUS_BASE | 16'h0033, 8'h10);
      reg_write(BUS_BASE | 16'h0034, 8'h05);
      reg_write(BUS_BASE | 16'h0035, 8'hFF);
      send_request(OP_PIXEL, '0, '0, '0, 8'hFF, 2'd0, 2'd0);
      send_request(OP_PIXEL, '0, '0, '0, 8'h00, 2'd0, 2'd0);
      send_request(OP_PIXEL, '1, '1, '1, 8'h01, 2'd3, 2'd3);
      send_request(OP_CAPTURE, '0, '0, 48'hFFFF_FFFF_FF00, '0, '0, '0);
      send_request(OP_READ, BUS_BASE, '0, '1, '0, '0, '0);
      send_request(OP_READ, BUS_BASE | 16'h0001, '0, '1, '0, '0, '0);
      send_request(OP_CAPTURE, '0, '0, '0, '0, '0, '0);
      send_request(OP_READ, BUS_BASE, '0, 48'd1081005, '0, '0, '0);
      send_request(OP_READ, BUS_BASE, '0, 48'd1081006, '0, '0, '0);

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            wait_drained();
         random_request();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
